### design/bba_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the buddy block allocator.
// No dependencies; imported by buddy_block_allocator_top.
package bba_pkg;

  // Request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOSPACE = 2'd1;
  localparam logic [1:0] STAT_BAD     = 2'd2;

  // One request transaction
  typedef struct packed {
    logic       kind;
    logic [8:0] block_count;
    logic [7:0] block_index;
  } bba_req_t;

  // One result transaction
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] result_index;
    logic [3:0] result_level;
  } bba_rsp_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SPLIT_RD,
    S_SPLIT_EV,
    S_MERGE_RD,
    S_MERGE_EV,
    S_SET_RD,
    S_SET_EV,
    S_FIN
  } bba_state_t;

endpackage

### design/buddy_block_allocator_top.sv
`timescale 1ns / 1ps
// Buddy block allocator: sequencer plus one word-wide free-mark memory.
// Depends on bba_pkg (request/result structs, status codes, states).

// Free marks live in a binary-tree node array (node 1 is the largest block),
// packed up to 32 marks per memory word and visited through a single
// read-modify-write port, each word in a read state and then an evaluate
// state. An allocate scans words upward from its level and then splits; a
// free takes merge steps, plus a set step when it merges up to the whole
// pool; a zero count, oversize allocate or bad free goes straight to the
// finish state, which waits while the result register is full.
// After reset and after every pool_levels write a clearing pass over every
// memory word rebuilds the store as one free whole-pool block; no request
// is taken during it.
// A finished result sits in an output register while the next request is
// taken. Result index and level are zero unless status is ok.
module buddy_block_allocator_top #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bba_pkg::bba_req_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bba_pkg::bba_rsp_t out_data,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata
);
  import bba_pkg::*;

  // Largest level that fits the pool, and derived storage geometry
  localparam int ML        = $clog2(MAX_BLOCKS + 1) - 1;
  localparam int IdBits    = ML + 1;
  localparam int LevelBits = $clog2(ML + 1);
  localparam int WordBits  = ((1 << ML) < 32) ? (1 << ML) : 32;
  localparam int BitBits   = $clog2(WordBits);
  localparam int AddrBits  = IdBits - BitBits;
  localparam int Depth     = 1 << AddrBits;

  typedef logic [IdBits-1:0]    id_t;
  typedef logic [LevelBits-1:0] lvl_t;
  typedef logic [WordBits-1:0]  word_t;
  typedef logic [AddrBits-1:0]  addr_t;

  // Saturated top level from a pool_levels value
  function automatic lvl_t sat_top(input logic [3:0] pl);
    logic [3:0] t;
    t = (pl == 4'd0) ? 4'd0 : pl - 4'd1;
    if (32'(t) > ML) return LevelBits'(ML);
    return LevelBits'(t);
  endfunction

  // State
  bba_state_t state_r, state_nxt;
  addr_t      addr_r, addr_nxt;
  lvl_t       x_r, x_nxt;
  lvl_t       lv_r, lv_nxt;
  id_t        id_r, id_nxt;
  logic [1:0] stat_r, stat_nxt;
  lvl_t       top_r, top_nxt;
  logic       out_valid_r, out_valid_nxt;
  bba_rsp_t   out_data_r, out_data_nxt;

  // Memory
  word_t mem [Depth];
  word_t rd_q;
  logic  mem_we;
  word_t mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= mem_wdata;
    end
    rd_q <= mem[addr_r];
  end

  // Request decode: floor and ceiling log2 of the count, free checks
  logic [3:0]  fl, cl;
  logic        cnt_zero, free_bad;
  logic [9:0]  free_end;
  logic [16:0] span;
  logic [7:0]  align_mask;
  logic [31:0] idx_ext;
  id_t         free_node;
  id_t         alloc_base;

  always_comb begin
    fl = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if (in_data.block_count[i]) fl = 4'(i);
    end
    cnt_zero = (in_data.block_count == 9'd0);
    cl = fl + 4'((in_data.block_count & (in_data.block_count - 9'd1)) != 9'd0);
    span = 17'(1) << top_r;
    free_end = 10'(in_data.block_index) + (10'(1) << fl);
    align_mask = (8'(1) << fl) - 8'd1;
    free_bad = (5'(fl) > 5'(top_r)) || ((in_data.block_index & align_mask) != 8'd0) ||
               (17'(free_end) > span);
    idx_ext = 32'(in_data.block_index);
    free_node = IdBits'({1'b1, idx_ext[ML-1:0]}) >> fl;
    alloc_base = IdBits'(1) << (LevelBits'(ML) - LevelBits'(cl));
  end

  // Scan of the current level: node range, word window, lowest free mark
  id_t              lvl_base, lvl_last;
  addr_t            first_w, last_w;
  word_t            lo_mask, hi_mask, hits;
  logic [BitBits-1:0] pick;
  logic             found;
  id_t              found_id, found_child, child_lo, child_hi, grand;
  logic [BitBits-1:0] bud_bit, own_bit;
  logic             bud_free;
  id_t              parent, blk;
  logic [31:0]      blk_ext, lvl_ext;

  always_comb begin
    lvl_base = IdBits'(1) << (LevelBits'(ML) - x_r);
    lvl_last = lvl_base + (IdBits'(1) << (top_r - x_r)) - IdBits'(1);
    first_w = lvl_base[IdBits-1:BitBits];
    last_w  = lvl_last[IdBits-1:BitBits];
    lo_mask = (addr_r == first_w) ? ({WordBits{1'b1}} << lvl_base[BitBits-1:0])
                                  : {WordBits{1'b1}};
    hi_mask = (addr_r == last_w) ? ({WordBits{1'b1}} >> (~lvl_last[BitBits-1:0]))
                                 : {WordBits{1'b1}};
    hits = rd_q & lo_mask & hi_mask;
    found = |hits;
    pick = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (hits[i]) pick = BitBits'(i);
    end
    found_id = {addr_r, pick};
    found_child = {found_id[IdBits-2:0], 1'b0};
    // split: lower child freed, upper child kept
    child_lo = {id_r[IdBits-2:0], 1'b0};
    child_hi = {id_r[IdBits-2:0], 1'b1};
    grand = {child_hi[IdBits-2:0], 1'b0};
    // merge: buddy shares the word
    own_bit = id_r[BitBits-1:0];
    bud_bit = own_bit ^ BitBits'(1);
    bud_free = rd_q[bud_bit];
    parent = id_r >> 1;
    // block index of node id_r at level x_r
    blk = id_r << x_r;
    blk_ext = 32'(blk[ML-1:0]);
    lvl_ext = 32'(x_r);
  end

  // Next state and datapath registers
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    x_nxt         = x_r;
    lv_nxt        = lv_r;
    id_nxt        = id_r;
    stat_nxt      = stat_r;
    top_nxt       = top_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    if (cfg_we) begin
      top_nxt   = sat_top(cfg_wdata);
      state_nxt = S_CLEAR;
      addr_nxt  = '0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          addr_nxt = addr_r + addr_t'(1);
          if (addr_r == addr_t'(Depth - 1)) state_nxt = S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            if (cnt_zero) begin
              stat_nxt  = STAT_BAD;
              state_nxt = S_FIN;
            end else if (in_data.kind == KIND_ALLOC) begin
              if (5'(cl) > 5'(top_r)) begin
                stat_nxt  = STAT_NOSPACE;
                state_nxt = S_FIN;
              end else begin
                x_nxt     = LevelBits'(cl);
                lv_nxt    = LevelBits'(cl);
                addr_nxt  = alloc_base[IdBits-1:BitBits];
                state_nxt = S_SCAN_RD;
              end
            end else if (free_bad) begin
              stat_nxt  = STAT_BAD;
              state_nxt = S_FIN;
            end else begin
              x_nxt     = LevelBits'(fl);
              id_nxt    = free_node;
              addr_nxt  = free_node[IdBits-1:BitBits];
              state_nxt = (LevelBits'(fl) == top_r) ? S_SET_RD : S_MERGE_RD;
            end
          end
        end
        S_SCAN_RD:  state_nxt = S_SCAN_EV;
        S_SCAN_EV: begin
          if (found) begin
            id_nxt = found_id;
            if (x_r > lv_r) begin
              addr_nxt  = found_child[IdBits-1:BitBits];
              state_nxt = S_SPLIT_RD;
            end else begin
              stat_nxt  = STAT_OK;
              state_nxt = S_FIN;
            end
          end else if (addr_r != last_w) begin
            addr_nxt  = addr_r + addr_t'(1);
            state_nxt = S_SCAN_RD;
          end else if (x_r == top_r) begin
            stat_nxt  = STAT_NOSPACE;
            state_nxt = S_FIN;
          end else begin
            // next level up: its first node is half of this level's
            x_nxt     = x_r + lvl_t'(1);
            addr_nxt  = addr_t'(lvl_base >> (BitBits + 1));
            state_nxt = S_SCAN_RD;
          end
        end
        S_SPLIT_RD: state_nxt = S_SPLIT_EV;
        S_SPLIT_EV: begin
          x_nxt  = x_r - lvl_t'(1);
          id_nxt = child_hi;
          if (x_r - lvl_t'(1) == lv_r) begin
            stat_nxt  = STAT_OK;
            state_nxt = S_FIN;
          end else begin
            addr_nxt  = grand[IdBits-1:BitBits];
            state_nxt = S_SPLIT_RD;
          end
        end
        S_MERGE_RD: state_nxt = S_MERGE_EV;
        S_MERGE_EV: begin
          if (bud_free) begin
            x_nxt     = x_r + lvl_t'(1);
            id_nxt    = parent;
            addr_nxt  = parent[IdBits-1:BitBits];
            state_nxt = (x_r + lvl_t'(1) == top_r) ? S_SET_RD : S_MERGE_RD;
          end else begin
            stat_nxt  = STAT_OK;
            state_nxt = S_FIN;
          end
        end
        S_SET_RD:   state_nxt = S_SET_EV;
        S_SET_EV: begin
          stat_nxt  = STAT_OK;
          state_nxt = S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = stat_r;
            if (stat_r == STAT_OK) begin
              out_data_nxt.result_index = blk_ext[7:0];
              out_data_nxt.result_level = lvl_ext[3:0];
            end else begin
              out_data_nxt.result_index = '0;
              out_data_nxt.result_level = '0;
            end
            state_nxt = S_IDLE;
          end
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  // Handshake and memory write port
  always_comb begin
    in_ready  = (state_r == S_IDLE) && !cfg_we;
    mem_we    = 1'b0;
    mem_wdata = rd_q;
    unique case (state_r)
      S_CLEAR: begin
        // only the whole-pool node is free
        mem_we    = 1'b1;
        mem_wdata = (addr_r == lvl_base[IdBits-1:BitBits] && x_r == top_r) ?
                    (word_t'(1) << lvl_base[BitBits-1:0]) : '0;
      end
      S_SCAN_EV: begin
        mem_we    = found;
        mem_wdata = rd_q & ~(word_t'(1) << pick);
      end
      S_SPLIT_EV: begin
        mem_we    = 1'b1;
        mem_wdata = rd_q | (word_t'(1) << child_lo[BitBits-1:0]);
      end
      S_MERGE_EV: begin
        mem_we    = 1'b1;
        mem_wdata = bud_free ? (rd_q & ~(word_t'(1) << bud_bit) & ~(word_t'(1) << own_bit))
                             : (rd_q | (word_t'(1) << own_bit));
      end
      S_SET_EV: begin
        mem_we    = 1'b1;
        mem_wdata = rd_q | (word_t'(1) << own_bit);
      end
      default: begin
        mem_we    = 1'b0;
        mem_wdata = rd_q;
      end
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      x_r         <= sat_top(4'd9);
      top_r       <= sat_top(4'd9);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      // during clearing the level register points at the top for the root lookup
      x_r         <= (state_nxt == S_CLEAR) ? top_nxt : x_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lv_r       <= lv_nxt;
    id_r       <= id_nxt;
    stat_r     <= stat_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Testbench for buddy_block_allocator_top: directed and random allocate/free traffic
// checked against an in-bench buddy pool predictor. Depends on bba_pkg and the RTL top.
module tb;
  import bba_pkg::*;

  localparam int POOL_BLOCKS = 256;
  localparam int TOP_MAX     = $clog2(POOL_BLOCKS);
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    int unsigned idx;
    int unsigned lv;
  } grant_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  bba_req_t in_data;
  logic     out_valid;
  logic     out_ready;
  bba_rsp_t out_data;
  logic     cfg_we;
  logic [3:0] cfg_wdata;

  // Predictor state: one free mark per (level, aligned block)
  bit          free_map [0:TOP_MAX][0:POOL_BLOCKS-1];
  int unsigned pool_top;

  bba_rsp_t    pending_rsp[$];
  grant_t      granted_blocks[$];
  grant_t      last_released;
  bit          have_released;

  int  fail_count  = 0;
  int  cycle_count = 0;
  bit  tx_idle_en  = 1'b1;
  bit  rx_idle_en  = 1'b1;
  bit  hold_req    = 1'b0;
  int  hold_left   = 0;

  buddy_block_allocator_top #(.MAX_BLOCKS(POOL_BLOCKS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Reload the pool as one free whole-pool block
  function automatic void rebuild_pool(logic [3:0] levels);
    pool_top = (levels == 4'd0) ? 0 : 32'(levels) - 1;
    if (pool_top > TOP_MAX) pool_top = TOP_MAX;
    foreach (free_map[l, b]) free_map[l][b] = 1'b0;
    free_map[pool_top][0] = 1'b1;
    granted_blocks.delete();
    have_released = 1'b0;
  endfunction

  // Allocate: smallest level first, lowest index first, keep the upper halves
  function automatic bba_rsp_t grant_blocks(int unsigned count);
    bba_rsp_t    r;
    int unsigned need, x, s;
    r = '0;
    if (count == 0) begin
      r.status = STAT_BAD;
      return r;
    end
    need = 0;
    while ((1 << need) < count) need++;
    if (need > pool_top) begin
      r.status = STAT_NOSPACE;
      return r;
    end
    for (x = need; x <= pool_top; x++) begin
      for (s = 0; s < (1 << pool_top); s += (1 << x)) begin
        if (free_map[x][s]) begin
          free_map[x][s] = 1'b0;
          while (x > need) begin
            x--;
            free_map[x][s] = 1'b1;
            s += (1 << x);
          end
          r.status       = STAT_OK;
          r.result_index = s[7:0];
          r.result_level = need[3:0];
          return r;
        end
      end
    end
    r.status = STAT_NOSPACE;
    return r;
  endfunction

  // Free: floor the count, then merge with the XOR buddy while it is free
  function automatic bba_rsp_t release_blocks(int unsigned count, int unsigned idx);
    bba_rsp_t    r;
    int unsigned lv, span, bud;
    r = '0;
    if (count == 0) begin
      r.status = STAT_BAD;
      return r;
    end
    lv = 0;
    while ((2 << lv) <= count) lv++;
    span = 1 << pool_top;
    if (lv > pool_top || (idx & ((1 << lv) - 1)) != 0 || idx >= span ||
        idx + (1 << lv) > span) begin
      r.status = STAT_BAD;
      return r;
    end
    while (lv < pool_top) begin
      bud = idx ^ (1 << lv);
      if (!free_map[lv][bud]) break;
      free_map[lv][bud] = 1'b0;
      free_map[lv][idx] = 1'b0;
      if (bud < idx) idx = bud;
      lv++;
    end
    free_map[lv][idx] = 1'b1;
    r.status       = STAT_OK;
    r.result_index = idx[7:0];
    r.result_level = lv[3:0];
    return r;
  endfunction

  function automatic bba_req_t mk_req(logic kind, logic [8:0] count, logic [7:0] idx);
    bba_req_t r;
    r.kind        = kind;
    r.block_count = count;
    r.block_index = idx;
    return r;
  endfunction

  // Mostly well-formed alloc/free pairs, some broken frees, some raw noise
  function automatic bba_req_t random_request();
    bba_req_t    r;
    int unsigned roll, k, lv;
    grant_t      g;
    roll = $urandom_range(99);
    r = mk_req(KIND_ALLOC, 9'd1, 8'($urandom_range(0, 255)));
    if (roll < 70) begin
      if (granted_blocks.size() > 0 && $urandom_range(1) == 1) begin
        k = $urandom_range(0, granted_blocks.size() - 1);
        g = granted_blocks[k];
        granted_blocks.delete(k);
        last_released = g;
        have_released = 1'b1;
        r.kind        = KIND_FREE;
        r.block_index = g.idx[7:0];
        r.block_count = 9'($urandom_range(1 << g.lv, (2 << g.lv) - 1));
      end else begin
        lv = $urandom_range(0, $urandom_range(0, pool_top));
        r.block_count = 9'((lv == 0) ? 1 : $urandom_range((1 << (lv - 1)) + 1, 1 << lv));
      end
    end else if (roll < 80) begin
      r.kind = KIND_FREE;
      if (have_released && $urandom_range(1) == 1) begin
        // double free of the last released block
        r.block_index = last_released.idx[7:0];
        r.block_count = 9'(1 << last_released.lv);
      end else begin
        // misaligned free
        lv = $urandom_range(1, TOP_MAX);
        r.block_count = 9'(1 << lv);
        r.block_index = 8'($urandom_range(0, 255) | 1);
      end
    end else begin
      r.kind        = 1'($urandom_range(1));
      r.block_count = 9'($urandom_range(0, 511));
      r.block_index = 8'($urandom_range(0, 255));
    end
    return r;
  endfunction

  function automatic bba_rsp_t predict_outcome(bba_req_t r);
    if (r.kind == KIND_ALLOC) return grant_blocks(32'(r.block_count));
    return release_blocks(32'(r.block_count), 32'(r.block_index));
  endfunction

  // Send one request transaction; called and returns at a falling edge.
  // Valid is left high so the next call can follow without a gap.
  task automatic offer_request(bba_req_t r);
    bba_rsp_t exp_rsp;
    grant_t   g;
    while (tx_idle_en && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp_rsp = predict_outcome(r);
    pending_rsp.push_back(exp_rsp);
    if (r.kind == KIND_ALLOC && exp_rsp.status == STAT_OK) begin
      g.idx = 32'(exp_rsp.result_index);
      g.lv  = 32'(exp_rsp.result_level);
      granted_blocks.push_back(g);
    end
    @(negedge clk);
  endtask

  // Drop valid and wait for every expected result
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  task automatic write_pool_levels(logic [3:0] levels);
    cfg_we    <= 1'b1;
    cfg_wdata <= levels;
    @(negedge clk);
    cfg_we    <= 1'b0;
    rebuild_pool(levels);
  endtask

  // Receiver: random stalls, or a long counted hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= !(rx_idle_en && $urandom_range(99) < 37);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    bba_rsp_t exp_rsp;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result transaction: status %0d index %0d level %0d",
               out_data.status, out_data.result_index, out_data.result_level);
        fail_count++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (out_data.status !== exp_rsp.status) begin
          $error("status: expected %0d, got %0d", exp_rsp.status, out_data.status);
          fail_count++;
        end
        if (out_data.result_index !== exp_rsp.result_index) begin
          $error("result_index: expected %0d, got %0d",
                 exp_rsp.result_index, out_data.result_index);
          fail_count++;
        end
        if (out_data.result_level !== exp_rsp.result_level) begin
          $error("result_level: expected %0d, got %0d",
                 exp_rsp.result_level, out_data.result_level);
          fail_count++;
        end
      end
    end
  end

  // Full pool at reset: whole-pool grant, zero counts, oversize, splits, merges
  task automatic test_boundaries();
    offer_request(mk_req(KIND_ALLOC, 9'd256, 8'd0));
    offer_request(mk_req(KIND_ALLOC, 9'd1,   8'd255));
    offer_request(mk_req(KIND_FREE,  9'd256, 8'd0));
    offer_request(mk_req(KIND_ALLOC, 9'd0,   8'd0));
    offer_request(mk_req(KIND_FREE,  9'd0,   8'd0));
    offer_request(mk_req(KIND_ALLOC, 9'd257, 8'd0));
    offer_request(mk_req(KIND_ALLOC, 9'd511, 8'd170));
    offer_request(mk_req(KIND_ALLOC, 9'd1,   8'd85));
    offer_request(mk_req(KIND_ALLOC, 9'd3,   8'd0));
    offer_request(mk_req(KIND_FREE,  9'd4,   8'd2));
    offer_request(mk_req(KIND_FREE,  9'd1,   8'd255));
    offer_request(mk_req(KIND_FREE,  9'd1,   8'd255));
    offer_request(mk_req(KIND_FREE,  9'd7,   8'd248));
    offer_request(mk_req(KIND_FREE,  9'd511, 8'd0));
    quiesce();
  endtask

  // Register extremes and a small pool: zero acts as one level, all-ones saturates
  task automatic test_pool_sizes();
    write_pool_levels(4'd0);
    offer_request(mk_req(KIND_ALLOC, 9'd1, 8'd0));
    offer_request(mk_req(KIND_ALLOC, 9'd1, 8'd0));
    offer_request(mk_req(KIND_FREE,  9'd1, 8'd0));
    quiesce();
    write_pool_levels(4'd3);
    offer_request(mk_req(KIND_FREE,  9'd1, 8'd4));
    offer_request(mk_req(KIND_FREE,  9'd8, 8'd0));
    offer_request(mk_req(KIND_ALLOC, 9'd5, 8'd0));
    offer_request(mk_req(KIND_ALLOC, 9'd2, 8'd0));
    quiesce();
    write_pool_levels(4'd15);
    offer_request(mk_req(KIND_ALLOC, 9'd256, 8'd0));
    offer_request(mk_req(KIND_FREE,  9'd256, 8'd0));
    quiesce();
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    int n;
    write_pool_levels(4'd9);
    tx_idle_en = 1'b0;
    hold_req   = 1'b1;
    for (n = 0; n < 24; n++) offer_request(random_request());
    quiesce();
    tx_idle_en = 1'b1;
  endtask

  // Sender stops until every result is back, then resumes on the same pool
  task automatic test_drain_pause();
    int n;
    for (n = 0; n < 12; n++) offer_request(random_request());
    quiesce();
    for (n = 0; n < 12; n++) offer_request(random_request());
    quiesce();
  endtask

  // Random traffic over several pool sizes, one phase with no idling at all
  task automatic test_random_traffic();
    int          phase, n;
    int unsigned levels;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       levels = 9;
        1:       levels = 1;
        5:       levels = 9;
        default: levels = $urandom_range(1, 9);
      endcase
      write_pool_levels(levels[3:0]);
      tx_idle_en = (phase != 2);
      rx_idle_en = (phase != 2);
      for (n = 0; n < 125; n++) offer_request(random_request());
      quiesce();
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = 4'd0;
    rebuild_pool(4'd9);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_boundaries();
    test_pool_sizes();
    test_backpressure();
    test_drain_pause();
    test_random_traffic();
    repeat (40) @(negedge clk);
    if (fail_count == 0 && pending_rsp.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
